// ===== hdl/wwvh_pkg.sv =====
package wwvh_pkg;

  localparam int POS_W      = 24;
  localparam int HEIGHT_W   = 24;
  localparam int PHASE_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int SINE_W     = 16;
  localparam int MAG_W      = 15;
  localparam int LANES      = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WATER_LEVEL = 2'd0,
    REG_SLOW_PHASE  = 2'd1,
    REG_FAST_PHASE  = 2'd2
  } cfg_reg_t;

  // Lanes 0 to 3 form the slow group, lanes 4 to 7 the fast group.
  localparam int LANE_COEF_X [LANES] = '{1, 1, -1, -1, 2, 1, -1, -2};
  localparam int LANE_COEF_Z [LANES] = '{1, -1, 1, -1, 1, -2, 2, -1};

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // One quarter-wave sine entry in Q14, from a truncating Q30 Taylor series.
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned table_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(k) * HALF_PI_Q30) >> (table_bits - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd210;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s + (64'd1 << 15)) >> 16;
    if (v > 64'd16384) begin
      v = 64'd16384;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

// ===== hdl/water_wave_vertex_height.sv =====
// Throughput: one vertex per clock while reset is not held, through the ten-stage pipeline
// (reciprocal division of x and z, eight sine lanes, weighted sum, final scale).
// Reset is synchronous and active high; it clears the stage valid bits and the three
// configuration registers, and busy is high only while reset is held.
// The receiver cannot stall, so results leave the output register one per cycle.
module water_wave_vertex_height #(
  parameter int TILE_SIZE       = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [wwvh_pkg::POS_W-1:0]    pos_x,
  input  logic signed [wwvh_pkg::POS_W-1:0]    pos_z,
  output logic                                 done,
  output logic signed [wwvh_pkg::HEIGHT_W-1:0] height,
  input  logic                                 cfg_write,
  input  logic [wwvh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wwvh_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wwvh_pkg::*;

  localparam int STAGES    = 10;
  localparam int STB       = SINE_TABLE_BITS;
  localparam int QBITS     = STB - 2;
  localparam int QUARTER   = 1 << QBITS;
  localparam int TILE_LOG  = $clog2(TILE_SIZE);
  localparam int RW        = TILE_LOG + 1;
  localparam int SW        = RW + 3;
  localparam int N_W       = 33;
  localparam int RECIP_W   = 35;
  localparam int DIV_SHIFT = N_W + TILE_LOG;

  localparam logic [63:0] OFS_Q     = ((64'd1 << 31) + 64'(TILE_SIZE) - 64'd1)
                                      / 64'(TILE_SIZE);
  localparam logic [63:0] OFS_FULL  = OFS_Q * 64'(TILE_SIZE);
  localparam logic [N_W-1:0] OFS_N  = OFS_FULL[N_W-1:0];
  localparam logic [15:0] OFS_Q16   = OFS_Q[15:0];
  localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_SHIFT) + 64'(TILE_SIZE) - 64'd1)
                                       / 64'(TILE_SIZE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam logic [RW-1:0]        TILE_R = RW'(TILE_SIZE);
  localparam logic signed [SW-1:0] TS_P2  = SW'(2 * TILE_SIZE);
  localparam logic signed [SW-1:0] TS_P1  = SW'(TILE_SIZE);
  localparam logic signed [SW-1:0] TS_M1  = SW'(-TILE_SIZE);
  localparam logic signed [SW-1:0] TS_M2  = SW'(-2 * TILE_SIZE);

  localparam logic [MAG_W-1:0] SINE_PEAK = sine_entry(QUARTER, STB);

  logic [MAG_W-1:0] sine_rom [QUARTER];

  for (genvar k = 0; k < QUARTER; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, STB);
  end

  logic signed [HEIGHT_W-1:0] water_level;
  logic [PHASE_W-1:0]         slow_phase;
  logic [PHASE_W-1:0]         fast_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      water_level <= '0;
      slow_phase  <= '0;
      fast_phase  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WATER_LEVEL: water_level <= cfg_data;
        REG_SLOW_PHASE:  slow_phase  <= cfg_data[PHASE_W-1:0];
        REG_FAST_PHASE:  fast_phase  <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic [STAGES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], start & ~busy};
    end
  end

  assign done = vld[STAGES-1];

  // Offset both coordinates by a multiple of the tile so that the division works on
  // non-negative values.
  logic [N_W-1:0] n_x;
  logic [N_W-1:0] n_z;

  always_ff @(posedge clk) begin
    n_x <= {pos_x[POS_W-1], pos_x, 8'h00} + OFS_N;
    n_z <= {pos_z[POS_W-1], pos_z, 8'h00} + OFS_N;
  end

  logic [50:0]   ph_x;
  logic [51:0]   pl_x;
  logic [50:0]   ph_z;
  logic [51:0]   pl_z;
  logic [RW-1:0] nlo_x2;
  logic [RW-1:0] nlo_z2;

  always_ff @(posedge clk) begin
    ph_x   <= n_x[32:17] * RECIP;
    pl_x   <= n_x[16:0] * RECIP;
    ph_z   <= n_z[32:17] * RECIP;
    pl_z   <= n_z[16:0] * RECIP;
    nlo_x2 <= n_x[RW-1:0];
    nlo_z2 <= n_z[RW-1:0];
  end

  logic [67:0]   prod_x;
  logic [67:0]   prod_z;
  logic [15:0]   quo_x;
  logic [15:0]   quo_z;
  logic [RW-1:0] nlo_x3;
  logic [RW-1:0] nlo_z3;

  always_comb begin
    prod_x = {ph_x, 17'h00000} + 68'(pl_x);
    prod_z = {ph_z, 17'h00000} + 68'(pl_z);
  end

  always_ff @(posedge clk) begin
    quo_x  <= prod_x[DIV_SHIFT +: 16];
    quo_z  <= prod_z[DIV_SHIFT +: 16];
    nlo_x3 <= nlo_x2;
    nlo_z3 <= nlo_z2;
  end

  logic [2*RW-1:0] back_x;
  logic [2*RW-1:0] back_z;
  logic [15:0]     q_x;
  logic [15:0]     q_z;
  logic [RW-1:0]   rem_x;
  logic [RW-1:0]   rem_z;

  always_comb begin
    back_x = quo_x[RW-1:0] * TILE_R;
    back_z = quo_z[RW-1:0] * TILE_R;
  end

  always_ff @(posedge clk) begin
    q_x   <= quo_x - OFS_Q16;
    q_z   <= quo_z - OFS_Q16;
    rem_x <= nlo_x3 - back_x[RW-1:0];
    rem_z <= nlo_z3 - back_z[RW-1:0];
  end

  logic signed [SW-1:0]     rem_xs;
  logic signed [SW-1:0]     rem_zs;
  logic [STB-1:0]           idx  [LANES];
  logic signed [SINE_W-1:0] sine [LANES];

  assign rem_xs = signed'({3'b000, rem_x});
  assign rem_zs = signed'({3'b000, rem_z});

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int CX = LANE_COEF_X[i];
    localparam int CZ = LANE_COEF_Z[i];

    logic signed [SW-1:0]  resid;
    logic signed [2:0]     wrap;
    logic [PHASE_W-1:0]    phase;
    logic [15:0]           ang;
    logic [1:0]            quad;
    logic [QBITS-1:0]      pos;
    logic [QBITS-1:0]      addr;
    logic [MAG_W-1:0]      mag;
    logic signed [SINE_W-1:0] mag_s;

    // The sum of the remainders carries a whole number of tiles into the angle.
    always_comb begin
      resid = SW'(CX) * rem_xs + SW'(CZ) * rem_zs;
      if (resid >= TS_P2) begin
        wrap = 3'sd2;
      end else if (resid >= TS_P1) begin
        wrap = 3'sd1;
      end else if (resid >= 0) begin
        wrap = 3'sd0;
      end else if (resid >= TS_M1) begin
        wrap = -3'sd1;
      end else if (resid >= TS_M2) begin
        wrap = -3'sd2;
      end else begin
        wrap = -3'sd3;
      end
      phase = (i >= LANES / 2) ? fast_phase : slow_phase;
      ang   = 16'(CX) * q_x + 16'(CZ) * q_z + 16'(wrap) + phase;
    end

    always_ff @(posedge clk) begin
      idx[i] <= ang[15 -: STB];
    end

    always_comb begin
      quad  = idx[i][STB-1:STB-2];
      pos   = idx[i][QBITS-1:0];
      addr  = quad[0] ? (QBITS'(0) - pos) : pos;
      mag   = (quad[0] && pos == '0) ? SINE_PEAK : sine_rom[addr];
      mag_s = signed'({1'b0, mag});
    end

    always_ff @(posedge clk) begin
      sine[i] <= quad[1] ? -mag_s : mag_s;
    end
  end

  logic signed [17:0] sum_slow;
  logic signed [17:0] sum_fast;

  always_ff @(posedge clk) begin
    sum_slow <= 18'(sine[0]) + 18'(sine[1]) + 18'(sine[2]) + 18'(sine[3]);
    sum_fast <= 18'(sine[4]) + 18'(sine[5]) + 18'(sine[6]) + 18'(sine[7]);
  end

  // The weighted sum divided by 1280 is taken as a shift by 256 and then a division by 5.
  logic signed [20:0] num;
  logic signed [12:0] coarse;

  always_comb begin
    num = (21'(sum_slow) <<< 3) + 21'(sum_fast) * 21'sd5 + 21'sd640;
  end

  always_ff @(posedge clk) begin
    coarse <= num[20:8];
  end

  logic [12:0]        biased;
  logic [26:0]        fifth;
  logic signed [11:0] wave;

  always_comb begin
    biased = coarse + 13'd3500;
    fifth  = biased * 14'd13108;
  end

  always_ff @(posedge clk) begin
    wave <= signed'({1'b0, fifth[26:16]}) - 12'sd700;
  end

  logic signed [HEIGHT_W:0] sum_h;

  always_comb begin
    sum_h = (HEIGHT_W + 1)'(water_level) + (HEIGHT_W + 1)'(wave);
  end

  always_ff @(posedge clk) begin
    if (sum_h[HEIGHT_W] != sum_h[HEIGHT_W-1]) begin
      height <= sum_h[HEIGHT_W] ? {1'b1, {(HEIGHT_W - 1){1'b0}}}
                                : {1'b0, {(HEIGHT_W - 1){1'b1}}};
    end else begin
      height <= sum_h[HEIGHT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##STAGES done)
    else $error("Accepted transaction did not complete after the pipeline latency.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, STAGES))
    else $error("Result strobe without a matching accepted transaction.");

  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (rem_x < TILE_R))
    else $error("Division of x left a remainder of a whole tile or more.");

  a_rem_z: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (rem_z < TILE_R))
    else $error("Division of z left a remainder of a whole tile or more.");
`endif

endmodule

// ===== bench/wave_height_checker.sv =====
`timescale 1ns / 1ps

module wave_height_checker #(
  parameter int TILE_SIZE       = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [wwvh_pkg::POS_W-1:0]    pos_x,
  input  logic signed [wwvh_pkg::POS_W-1:0]    pos_z,
  input  logic                                 done,
  input  logic signed [wwvh_pkg::HEIGHT_W-1:0] height,
  input  logic                                 cfg_write,
  input  logic [wwvh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wwvh_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 drained,
  output int                                   mismatch_count
);
  import wwvh_pkg::*;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint HEIGHT_MAX = (64'sd1 <<< (HEIGHT_W - 1)) - 1;
  localparam longint HEIGHT_MIN = -(64'sd1 <<< (HEIGHT_W - 1));

  int sine_quarter [QUARTER+1];
  logic signed [HEIGHT_W-1:0] surf_level;
  logic [PHASE_W-1:0] slow_turn;
  logic [PHASE_W-1:0] fast_turn;
  logic signed [HEIGHT_W-1:0] heights_due [$];
  logic signed [HEIGHT_W-1:0] want;

  initial begin
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] series;
    logic [63:0] mag;
    for (int k = 0; k <= QUARTER; k++) begin
      ang    = (64'(k) * QUARTER_TURN_Q30) / 64'(QUARTER);
      ang_sq = (ang * ang) >> 30;
      series = Q30_ONE;
      for (int n = 7; n >= 1; n--) begin
        series = Q30_ONE - ((ang_sq * series) >> 30) / 64'((2 * n) * (2 * n + 1));
      end
      mag = (((ang * series) >> 30) + (64'd1 << 15)) >> 16;
      if (mag > 64'd16384) begin
        mag = 64'd16384;
      end
      sine_quarter[k] = int'(mag);
    end
  end

  function automatic int wave_sine(input longint lin, input logic [PHASE_W-1:0] phase);
    longint scaled;
    longint turn;
    logic [15:0] ang;
    int unsigned idx;
    int unsigned quad;
    int unsigned pos;
    scaled = lin * 256;
    turn = scaled / TILE_SIZE;
    if ((scaled % TILE_SIZE) != 0 && scaled < 0) begin
      turn--;
    end
    ang  = 16'(turn + longint'(phase));
    idx  = 32'(ang >> (16 - SINE_TABLE_BITS));
    quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
    pos  = idx & (QUARTER - 1);
    case (quad)
      0: begin
        return sine_quarter[pos];
      end
      1: begin
        return sine_quarter[QUARTER - pos];
      end
      2: begin
        return -sine_quarter[pos];
      end
      default: begin
        return -sine_quarter[QUARTER - pos];
      end
    endcase
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] predict_height(
    input logic signed [POS_W-1:0] x,
    input logic signed [POS_W-1:0] z
  );
    longint px;
    longint pz;
    longint slow_sum;
    longint fast_sum;
    longint num;
    longint wave;
    longint h;
    px = longint'(x);
    pz = longint'(z);
    slow_sum = wave_sine(px + pz, slow_turn) + wave_sine(px - pz, slow_turn)
             + wave_sine(-px + pz, slow_turn) + wave_sine(-px - pz, slow_turn);
    fast_sum = wave_sine(2 * px + pz, fast_turn) + wave_sine(px - 2 * pz, fast_turn)
             + wave_sine(-px + 2 * pz, fast_turn) + wave_sine(-2 * px - pz, fast_turn);
    num  = 8 * slow_sum + 5 * fast_sum + 640;
    wave = num / 1280;
    if ((num % 1280) != 0 && num < 0) begin
      wave--;
    end
    h = longint'(surf_level) + wave;
    if (h > HEIGHT_MAX) begin
      h = HEIGHT_MAX;
    end
    if (h < HEIGHT_MIN) begin
      h = HEIGHT_MIN;
    end
    return h[HEIGHT_W-1:0];
  endfunction

  initial begin
    drained = 1'b1;
    mismatch_count = 0;
    surf_level = '0;
    slow_turn = '0;
    fast_turn = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      heights_due.delete();
      surf_level = '0;
      slow_turn = '0;
      fast_turn = '0;
    end else begin
      if (done) begin
        // A result arriving with no transaction outstanding counts as a mismatch.
        if (heights_due.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("checker: height %0d with no transaction outstanding", height);
          end
          mismatch_count++;
        end else begin
          want = heights_due.pop_front();
          if (height !== want) begin
            if (mismatch_count < 10) begin
              $display("checker: height expected %0d, actual %0d", want, height);
            end
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        heights_due.insert(heights_due.size(), predict_height(pos_x, pos_z));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_WATER_LEVEL: begin
            surf_level = cfg_data[HEIGHT_W-1:0];
          end
          REG_SLOW_PHASE: begin
            slow_turn = cfg_data[PHASE_W-1:0];
          end
          REG_FAST_PHASE: begin
            fast_turn = cfg_data[PHASE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    drained <= (heights_due.size() == 0);
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import wwvh_pkg::*;

  localparam int TILE_SIZE       = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int VERTS_PER_PHASE = 250;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
  localparam logic [POS_W-1:0] POS_MIN = 24'h800000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_z;
  logic done;
  logic signed [HEIGHT_W-1:0] height;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic drained;
  int mismatch_count;
  int quiet_cycles;

  water_wave_vertex_height #(
    .TILE_SIZE(TILE_SIZE),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pos_x(pos_x),
    .pos_z(pos_z),
    .done(done),
    .height(height),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  wave_height_checker #(
    .TILE_SIZE(TILE_SIZE),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pos_x(pos_x),
    .pos_z(pos_z),
    .done(done),
    .height(height),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .drained(drained),
    .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_vertex(input logic [POS_W-1:0] x, input logic [POS_W-1:0] z,
                             input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= x;
    pos_z <= z;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (!drained) begin
      @(posedge clk);
    end
  endtask

  task automatic program_waves(input logic [CFG_DATA_W-1:0] level,
                               input logic [CFG_DATA_W-1:0] slow,
                               input logic [CFG_DATA_W-1:0] fast);
    cfg_write <= 1'b1;
    cfg_index <= REG_WATER_LEVEL;
    cfg_data  <= level;
    @(posedge clk);
    cfg_index <= REG_SLOW_PHASE;
    cfg_data  <= slow;
    @(posedge clk);
    cfg_index <= REG_FAST_PHASE;
    cfg_data  <= fast;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom());
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      return POS_W'(int'($urandom_range(262143)) - 131072);
    end else if (pick < 90) begin
      return POS_W'($urandom());
    end else if (pick < 95) begin
      return POS_MAX - POS_W'($urandom_range(255));
    end else begin
      return POS_MIN + POS_W'($urandom_range(255));
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_level();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return CFG_DATA_W'(int'($urandom_range(32767)) - 16384);
    end else if (pick < 70) begin
      return CFG_DATA_W'($urandom());
    end else if (pick < 85) begin
      return CFG_DATA_W'(POS_MAX) - CFG_DATA_W'($urandom_range(700));
    end else begin
      return CFG_DATA_W'(POS_MIN) + CFG_DATA_W'($urandom_range(700));
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_phase();
    int unsigned pick;
    logic [PHASE_W-1:0] turn;
    pick = $urandom_range(99);
    if (pick < 20) begin
      turn = '0;
    end else if (pick < 30) begin
      turn = '1;
    end else begin
      turn = PHASE_W'($urandom());
    end
    return {(CFG_DATA_W - PHASE_W)'($urandom()), turn};
  endfunction

  initial begin
    int idle_pct;
    rst       = 1'b1;
    start     = 1'b0;
    pos_x     = '0;
    pos_z     = '0;
    cfg_write = 1'b0;
    cfg_index = REG_WATER_LEVEL;
    cfg_data  = '0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_vertex(24'h000000, 24'h000000, 0);
    send_vertex(POS_MAX, POS_MAX, 0);
    send_vertex(POS_MIN, POS_MIN, 0);
    send_vertex(POS_MAX, POS_MIN, 0);
    send_vertex(POS_MIN, POS_MAX, 0);
    send_vertex(24'hFFFFFF, 24'hFFFFFF, 0);
    send_vertex(24'h000001, 24'hFFFFFF, 0);
    send_vertex(24'h000100, 24'h000000, 0);
    send_vertex(24'h000000, 24'h002000, 0);
    send_vertex(24'h555555, 24'hAAAAAA, 0);
    send_vertex(24'hAAAAAA, 24'h555555, 0);
    wait_drained();

    program_waves(CFG_DATA_W'(POS_MAX), 24'hFF4000, 24'h004000);
    send_vertex(24'h000000, 24'h000000, 0);
    send_vertex(24'h000001, 24'h000000, 0);
    send_vertex(POS_MAX, POS_MIN, 0);
    wait_drained();

    program_waves(CFG_DATA_W'(POS_MIN), 24'h00C000, 24'hABC000);
    send_vertex(24'h000000, 24'h000000, 0);
    send_vertex(24'h000000, 24'hFFFFFF, 0);
    send_vertex(POS_MIN, POS_MAX, 0);
    wait_drained();

    program_waves(24'h000000, 24'hFFFFFF, 24'h00FFFF);
    send_vertex(24'h000000, 24'h000000, 0);
    send_vertex(24'h001234, 24'hFEDCBA, 0);
    send_vertex(POS_MAX, POS_MAX, 0);
    wait_drained();

    for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
      case (phase_no % 4)
        1: idle_pct = 69;
        3: idle_pct = 23;
        default: idle_pct = 0;
      endcase
      program_waves(random_level(), random_phase(), random_phase());
      for (int n = 0; n < VERTS_PER_PHASE; n++) begin
        send_vertex(random_coord(), random_coord(), idle_pct);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wwvh_pkg.sv
hdl/water_wave_vertex_height.sv
bench/wave_height_checker.sv
bench/testbench.sv
